// ===== rtl/rmq_pkg.sv =====
`default_nettype none

package rmq_pkg;

   localparam int unsigned DATA_W          = 16;
   localparam int unsigned RSUM_W          = DATA_W + 3;      // three terms plus the constant one
   localparam int unsigned DIFF_W          = DATA_W + 1;
   localparam int unsigned ROOT_W          = 15;              // largest magnitude is 21673
   localparam int unsigned RAD_W           = 2 * ROOT_W;
   localparam int unsigned REM_W           = ROOT_W + 2;
   localparam int unsigned FRAC_SHIFT      = 12;              // s * 4096
   localparam int unsigned STEPS_PER_STAGE = 3;
   localparam int unsigned ROOT_STAGES     = ROOT_W / STEPS_PER_STAGE;
   localparam int unsigned LANES           = 4;
   localparam int unsigned SIGNS           = 3;

   localparam logic signed [RSUM_W-1:0] Q_ONE   = RSUM_W'(16384);
   localparam logic        [DATA_W-1:0] MAX_MAG = DATA_W'(21675);

   // lane order inside a pipeline item
   localparam int unsigned LANE_X = 0;
   localparam int unsigned LANE_Y = 1;
   localparam int unsigned LANE_Z = 2;
   localparam int unsigned LANE_W = 3;

   typedef logic signed [DATA_W-1:0] elem_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;    // radicand bits still to be consumed, MSB first
      logic [REM_W-1:0]  rem;    // partial remainder
      logic [ROOT_W-1:0] root;   // root bits found so far
   } lane_type;

   typedef struct packed {
      lane_type [LANES-1:0] lane;
      logic     [SIGNS-1:0] neg;  // vector part takes a negative sign
   } root_item_type;

   // One restoring digit step: bring down two radicand bits, try (4*root + 1).
   function automatic lane_type root_step(lane_type a);
      lane_type         r;
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      shifted = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
      trial   = {a.root, 2'b01};
      r.rad   = {a.rad[RAD_W-3:0], 2'b00};
      if (shifted >= trial) begin
         r.rem  = shifted - trial;
         r.root = {a.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = shifted;
         r.root = {a.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rmq_radicand.sv =====
`default_nettype none

module rmq_radicand (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire rmq_pkg::elem_type     r00,
   input  wire rmq_pkg::elem_type     r01,
   input  wire rmq_pkg::elem_type     r02,
   input  wire rmq_pkg::elem_type     r10,
   input  wire rmq_pkg::elem_type     r11,
   input  wire rmq_pkg::elem_type     r12,
   input  wire rmq_pkg::elem_type     r20,
   input  wire rmq_pkg::elem_type     r21,
   input  wire rmq_pkg::elem_type     r22,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output rmq_pkg::root_item_type     out_item
);

   logic                         valid_ff;
   rmq_pkg::root_item_type       item_ff;
   rmq_pkg::root_item_type       item_in;
   logic signed [rmq_pkg::RSUM_W-1:0] a00, a11, a22;
   logic signed [rmq_pkg::RSUM_W-1:0] s_x, s_y, s_z, s_w;
   logic signed [rmq_pkg::DIFF_W-1:0] d_x, d_y, d_z;

   // clamp a negative radicand to zero and scale by 4096
   function automatic rmq_pkg::lane_type lane_init(logic signed [rmq_pkg::RSUM_W-1:0] s);
      rmq_pkg::lane_type l;
      l.rem  = '0;
      l.root = '0;
      if (s[rmq_pkg::RSUM_W-1]) begin
         l.rad = '0;
      end else begin
         l.rad = {s[rmq_pkg::RAD_W-rmq_pkg::FRAC_SHIFT-1:0], {rmq_pkg::FRAC_SHIFT{1'b0}}};
      end
      return l;
   endfunction

   function automatic logic signed [rmq_pkg::DIFF_W-1:0] diff(rmq_pkg::elem_type a,
                                                              rmq_pkg::elem_type b);
      return {a[rmq_pkg::DATA_W-1], a} - {b[rmq_pkg::DATA_W-1], b};
   endfunction

   always_comb begin
      a00 = rmq_pkg::RSUM_W'(r00);
      a11 = rmq_pkg::RSUM_W'(r11);
      a22 = rmq_pkg::RSUM_W'(r22);
      s_x = a00 - a11 - a22 + rmq_pkg::Q_ONE;
      s_y = a11 - a22 - a00 + rmq_pkg::Q_ONE;
      s_z = a22 - a00 - a11 + rmq_pkg::Q_ONE;
      s_w = a00 + a11 + a22 + rmq_pkg::Q_ONE;
      d_x = diff(r21, r12);
      d_y = diff(r02, r20);
      d_z = diff(r10, r01);
      item_in.lane[rmq_pkg::LANE_X] = lane_init(s_x);
      item_in.lane[rmq_pkg::LANE_Y] = lane_init(s_y);
      item_in.lane[rmq_pkg::LANE_Z] = lane_init(s_z);
      item_in.lane[rmq_pkg::LANE_W] = lane_init(s_w);
      item_in.neg = {d_z[rmq_pkg::DIFF_W-1], d_y[rmq_pkg::DIFF_W-1], d_x[rmq_pkg::DIFF_W-1]};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rmq_root_stage.sv =====
`default_nettype none

module rmq_root_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire rmq_pkg::root_item_type  in_item,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output rmq_pkg::root_item_type       out_item
);

   logic                   valid_ff;
   rmq_pkg::root_item_type item_ff;
   rmq_pkg::root_item_type item_in;

   // advance every lane by a few root digits
   always_comb begin
      item_in = in_item;
      for (int s = 0; s < rmq_pkg::STEPS_PER_STAGE; s++) begin
         for (int l = 0; l < rmq_pkg::LANES; l++) begin
            item_in.lane[l] = rmq_pkg::root_step(item_in.lane[l]);
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rmq_sign.sv =====
`default_nettype none

module rmq_sign (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire rmq_pkg::root_item_type  in_item,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output rmq_pkg::elem_type            qx,
   output rmq_pkg::elem_type            qy,
   output rmq_pkg::elem_type            qz,
   output rmq_pkg::elem_type            qw
);

   logic              valid_ff;
   rmq_pkg::elem_type qx_ff, qy_ff, qz_ff, qw_ff;
   rmq_pkg::elem_type qx_in, qy_in, qz_in, qw_in;

   function automatic rmq_pkg::elem_type signed_mag(logic [rmq_pkg::ROOT_W-1:0] mag,
                                                    logic neg);
      rmq_pkg::elem_type m;
      m = rmq_pkg::elem_type'({1'b0, mag});
      return neg ? -m : m;
   endfunction

   always_comb begin
      qx_in = signed_mag(in_item.lane[rmq_pkg::LANE_X].root, in_item.neg[rmq_pkg::LANE_X]);
      qy_in = signed_mag(in_item.lane[rmq_pkg::LANE_Y].root, in_item.neg[rmq_pkg::LANE_Y]);
      qz_in = signed_mag(in_item.lane[rmq_pkg::LANE_Z].root, in_item.neg[rmq_pkg::LANE_Z]);
      qw_in = signed_mag(in_item.lane[rmq_pkg::LANE_W].root, 1'b0);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign qx        = qx_ff;
   assign qy        = qy_ff;
   assign qz        = qz_ff;
   assign qw        = qw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         qz_ff <= qz_in;
         qw_ff <= qw_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
`default_nettype none

// Channel  | Ports                         | Transfer when      | Payload
// ---------+-------------------------------+--------------------+---------------------------
// request  | req_valid / req_ready / req_* | req_valid & ready  | r00..r22, signed Q2.14
// response | rsp_valid / rsp_ready / rsp_* | rsp_valid & ready  | qx, qy, qz, qw, signed Q2.14
//
// The pipeline has one radicand stage, five square-root stages of three
// digits each (15 root bits on four lanes in parallel), one sign/output stage.
// One matrix is accepted every cycle while the response side keeps up.
// Each stage holds its own valid bit; a stall backs up only as far as the
// first empty stage, so bubbles are squeezed out and nothing is lost or repeated.
// Reset (synchronous, active high) clears the valid bits only.

module rotation_matrix_to_quaternion_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire rmq_pkg::elem_type  req_r00,
   input  wire rmq_pkg::elem_type  req_r01,
   input  wire rmq_pkg::elem_type  req_r02,
   input  wire rmq_pkg::elem_type  req_r10,
   input  wire rmq_pkg::elem_type  req_r11,
   input  wire rmq_pkg::elem_type  req_r12,
   input  wire rmq_pkg::elem_type  req_r20,
   input  wire rmq_pkg::elem_type  req_r21,
   input  wire rmq_pkg::elem_type  req_r22,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rmq_pkg::elem_type       rsp_qx,
   output rmq_pkg::elem_type       rsp_qy,
   output rmq_pkg::elem_type       rsp_qz,
   output rmq_pkg::elem_type       rsp_qw
);

   // index 0 is the radicand stage, then the root stages; the last feeds the output stage
   logic                   stage_valid [rmq_pkg::ROOT_STAGES+1];
   logic                   stage_ready [rmq_pkg::ROOT_STAGES+1];
   rmq_pkg::root_item_type stage_item  [rmq_pkg::ROOT_STAGES+1];
   logic                   out_ready_unused;

   // form the four radicands and the three signs
   rmq_radicand u_radicand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .r00       (req_r00),
      .r01       (req_r01),
      .r02       (req_r02),
      .r10       (req_r10),
      .r11       (req_r11),
      .r12       (req_r12),
      .r20       (req_r20),
      .r21       (req_r21),
      .r22       (req_r22),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_item  (stage_item[0])
   );

   // square-root pipeline: each stage hands its ready back to the one before
   for (genvar g = 0; g < rmq_pkg::ROOT_STAGES; g++) begin : g_root
      rmq_root_stage u_root (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_item   (stage_item[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_item  (stage_item[g+1])
      );
   end

   // apply signs and hold the result for the response transfer
   rmq_sign u_sign (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[rmq_pkg::ROOT_STAGES]),
      .in_ready  (stage_ready[rmq_pkg::ROOT_STAGES]),
      .in_item   (stage_item[rmq_pkg::ROOT_STAGES]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .qx        (rsp_qx),
      .qy        (rsp_qy),
      .qz        (rsp_qz),
      .qw        (rsp_qw)
   );

   assign out_ready_unused = stage_ready[rmq_pkg::ROOT_STAGES];

   // the scalar part is never negative
   a_qw_positive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_qw[rmq_pkg::DATA_W-1])
      else $error("qw negative");

   // the scalar part never exceeds MAX_MAG, just above the largest possible root
   a_qw_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_qw <= rmq_pkg::MAX_MAG))
      else $error("qw beyond bound");

   // the request side stalls only when every stage is full and the output waits
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (stage_valid[0] && stage_valid[rmq_pkg::ROOT_STAGES]
                      && out_ready_unused == 1'b0 && rsp_valid && !rsp_ready))
      else $error("request stalled with a bubble in the pipeline");

   // nothing leaves the cycle after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

`default_nettype wire

// ===== sim/rotation_matrix_to_quaternion_core_tb.sv =====
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_core_tb;

   // Element positions inside a matrix, row-major
   localparam int R00 = 0;
   localparam int R01 = 1;
   localparam int R02 = 2;
   localparam int R10 = 3;
   localparam int R11 = 4;
   localparam int R12 = 5;
   localparam int R20 = 6;
   localparam int R21 = 7;
   localparam int R22 = 8;

   localparam int ONE_Q14      = 16384;
   localparam int RANDOM_MATS  = 1250;
   localparam int DRAIN_PERIOD = 250;

   typedef struct packed {
      rmq_pkg::elem_type [0:8] e;        // r00 .. r22
      logic                    drain;    // hold this matrix back until the pipeline is empty
   } matrix_item_type;

   typedef struct packed {
      rmq_pkg::elem_type x;
      rmq_pkg::elem_type y;
      rmq_pkg::elem_type z;
      rmq_pkg::elem_type w;
   } quat_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_LONG_STALLS
   } rsp_mode_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rmq_pkg::elem_type req_r00   = '0;
   rmq_pkg::elem_type req_r01   = '0;
   rmq_pkg::elem_type req_r02   = '0;
   rmq_pkg::elem_type req_r10   = '0;
   rmq_pkg::elem_type req_r11   = '0;
   rmq_pkg::elem_type req_r12   = '0;
   rmq_pkg::elem_type req_r20   = '0;
   rmq_pkg::elem_type req_r21   = '0;
   rmq_pkg::elem_type req_r22   = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rmq_pkg::elem_type rsp_qx;
   rmq_pkg::elem_type rsp_qy;
   rmq_pkg::elem_type rsp_qz;
   rmq_pkg::elem_type rsp_qw;

   matrix_item_type pending_mats[$];
   quat_type        expected_quats[$];
   matrix_item_type cur_mat;
   int              mismatch_count = 0;

   // sender burst/gap bookkeeping
   int gap_left   = 0;
   int burst_left = 1;

   // receiver stall pattern
   rsp_mode_type rsp_mode      = READY_ALWAYS;
   int           rsp_mode_left = 0;
   int           stall_left    = 0;

   rotation_matrix_to_quaternion_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_r00   (req_r00),
      .req_r01   (req_r01),
      .req_r02   (req_r02),
      .req_r10   (req_r10),
      .req_r11   (req_r11),
      .req_r12   (req_r12),
      .req_r20   (req_r20),
      .req_r21   (req_r21),
      .req_r22   (req_r22),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_qx    (rsp_qx),
      .rsp_qy    (rsp_qy),
      .rsp_qz    (rsp_qz),
      .rsp_qw    (rsp_qw)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Quaternion predictor
   // ------------------------------------------------------------------

   // Floor of the square root, built bit by bit from the top.
   function automatic int floor_root(int v);
      int     r;
      longint c;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
         c = longint'(r | (1 << b));
         if (c * c <= longint'(v))
            r = int'(c);
      end
      return r;
   endfunction

   // Half root of a Q2.14 radicand, in Q2.14: floor(sqrt(s * 2^12)).
   // Rounding may push the radicand below zero: clamp it first.
   function automatic int half_root_mag(int s);
      if (s < 0)
         s = 0;
      return floor_root(s * 4096);
   endfunction

   // A zero difference counts as positive.
   function automatic rmq_pkg::elem_type signed_part(int mag, int d);
      return (d < 0) ? rmq_pkg::elem_type'(-mag) : rmq_pkg::elem_type'(mag);
   endfunction

   function automatic quat_type predict_quat(matrix_item_type m);
      int       a [9];
      quat_type q;
      for (int i = 0; i < 9; i++)
         a[i] = int'($signed(m.e[i]));
      q.x = signed_part(half_root_mag(a[R00] - a[R11] - a[R22] + ONE_Q14), a[R21] - a[R12]);
      q.y = signed_part(half_root_mag(a[R11] - a[R22] - a[R00] + ONE_Q14), a[R02] - a[R20]);
      q.z = signed_part(half_root_mag(a[R22] - a[R00] - a[R11] + ONE_Q14), a[R10] - a[R01]);
      q.w = rmq_pkg::elem_type'(half_root_mag(a[R00] + a[R11] + a[R22] + ONE_Q14));
      return q;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------

   function automatic matrix_item_type make_mat(int e00, int e01, int e02,
                                                int e10, int e11, int e12,
                                                int e20, int e21, int e22,
                                                logic drain);
      matrix_item_type m;
      m.e[R00] = rmq_pkg::elem_type'(e00);
      m.e[R01] = rmq_pkg::elem_type'(e01);
      m.e[R02] = rmq_pkg::elem_type'(e02);
      m.e[R10] = rmq_pkg::elem_type'(e10);
      m.e[R11] = rmq_pkg::elem_type'(e11);
      m.e[R12] = rmq_pkg::elem_type'(e12);
      m.e[R20] = rmq_pkg::elem_type'(e20);
      m.e[R21] = rmq_pkg::elem_type'(e21);
      m.e[R22] = rmq_pkg::elem_type'(e22);
      m.drain  = drain;
      return m;
   endfunction

   // Real to Q2.14 with a jitter of a couple of LSBs, so radicands near zero
   // land on both sides of it.
   function automatic rmq_pkg::elem_type to_q14(real v);
      int k;
      k = $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5)) + int'($urandom_range(0, 4)) - 2;
      if (k > 32767)
         k = 32767;
      if (k < -32768)
         k = -32768;
      return rmq_pkg::elem_type'(k);
   endfunction

   // Rotation from a random quaternion; now and then one component is zeroed
   // to hit half-turns and zero off-diagonal differences.
   function automatic matrix_item_type random_rotation();
      matrix_item_type m;
      real             qw, qx, qy, qz, n;
      qw = real'(int'($urandom_range(0, 2000)) - 1000);
      qx = real'(int'($urandom_range(0, 2000)) - 1000);
      qy = real'(int'($urandom_range(0, 2000)) - 1000);
      qz = real'(int'($urandom_range(0, 2000)) - 1000);
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0: qw = 0.0;
            1: qx = 0.0;
            2: qy = 0.0;
            default: qz = 0.0;
         endcase
      end
      n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
      if (n < 1.0) begin
         qw = 1.0;
         n  = 1.0;
      end
      qw = qw / n;
      qx = qx / n;
      qy = qy / n;
      qz = qz / n;
      m.e[R00] = to_q14(1.0 - 2.0 * (qy * qy + qz * qz));
      m.e[R01] = to_q14(2.0 * (qx * qy - qw * qz));
      m.e[R02] = to_q14(2.0 * (qx * qz + qw * qy));
      m.e[R10] = to_q14(2.0 * (qx * qy + qw * qz));
      m.e[R11] = to_q14(1.0 - 2.0 * (qx * qx + qz * qz));
      m.e[R12] = to_q14(2.0 * (qy * qz - qw * qx));
      m.e[R20] = to_q14(2.0 * (qx * qz - qw * qy));
      m.e[R21] = to_q14(2.0 * (qy * qz + qw * qx));
      m.e[R22] = to_q14(1.0 - 2.0 * (qx * qx + qy * qy));
      m.drain  = 1'b0;
      return m;
   endfunction

   function automatic rmq_pkg::elem_type pick_extreme();
      case ($urandom_range(0, 5))
         0: return rmq_pkg::elem_type'(-32768);
         1: return rmq_pkg::elem_type'(32767);
         2: return rmq_pkg::elem_type'(0);
         3: return rmq_pkg::elem_type'(16384);
         4: return rmq_pkg::elem_type'(-16384);
         default: return rmq_pkg::elem_type'(-1);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Driver: present queued matrices in bursts, hold each until its transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict on the transfer itself, from the payload actually presented
         if (req_valid && req_ready)
            expected_quats.push_back(predict_quat(cur_mat));

         if (req_valid && !req_ready) begin
            // hold: valid and payload stay as they are
         end else if (pending_mats.size() != 0 && gap_left == 0 &&
                      !(pending_mats[0].drain && expected_quats.size() != 0)) begin
            cur_mat = pending_mats.pop_front();
            req_valid <= 1'b1;
            req_r00   <= cur_mat.e[R00];
            req_r01   <= cur_mat.e[R01];
            req_r02   <= cur_mat.e[R02];
            req_r10   <= cur_mat.e[R10];
            req_r11   <= cur_mat.e[R11];
            req_r12   <= cur_mat.e[R12];
            req_r20   <= cur_mat.e[R20];
            req_r21   <= cur_mat.e[R21];
            req_r22   <= cur_mat.e[R22];
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               // a quarter of the bursts run straight into the next one
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0)
               gap_left--;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each response transfer, then pick the next ready value
   // ------------------------------------------------------------------
   function automatic void check_part(string part, rmq_pkg::elem_type exp_v,
                                      rmq_pkg::elem_type act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d",
                  $time, part, $signed(exp_v), $signed(act_v));
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      quat_type exp_q;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_quats.size() == 0) begin
               $display("%0t: response with nothing expected, actual %0d %0d %0d %0d",
                        $time, rsp_qx, rsp_qy, rsp_qz, rsp_qw);
               mismatch_count++;
            end else begin
               exp_q = expected_quats.pop_front();
               check_part("qx", exp_q.x, rsp_qx);
               check_part("qy", exp_q.y, rsp_qy);
               check_part("qz", exp_q.z, rsp_qz);
               check_part("qw", exp_q.w, rsp_qw);
            end
         end

         // advance the stall pattern; each mode lasts a random stretch
         if (rsp_mode_left == 0) begin
            rsp_mode      = rsp_mode_type'($urandom_range(0, 3));
            rsp_mode_left = $urandom_range(32, 256);
         end else begin
            rsp_mode_left--;
         end

         case (rsp_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
            READY_RARELY: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
                  stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
               end
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      matrix_item_type m;

      // Directed: identity, half-turns (trace -1 gives a zero scalar part)
      pending_mats.push_back(make_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1'b0));
      pending_mats.push_back(make_mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384, 1'b0));
      pending_mats.push_back(make_mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384, 1'b0));
      pending_mats.push_back(make_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384, 1'b0));
      // quarter turns both ways about each axis: positive and negative differences
      pending_mats.push_back(make_mat(16384, 0, 0, 0, 0, -16384, 0, 16384, 0, 1'b0));
      pending_mats.push_back(make_mat(16384, 0, 0, 0, 0, 16384, 0, -16384, 0, 1'b0));
      pending_mats.push_back(make_mat(0, 0, 16384, 0, 16384, 0, -16384, 0, 0, 1'b0));
      pending_mats.push_back(make_mat(0, 0, -16384, 0, 16384, 0, 16384, 0, 0, 1'b0));
      pending_mats.push_back(make_mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384, 1'b0));
      pending_mats.push_back(make_mat(0, 16384, 0, -16384, 0, 0, 0, 0, 16384, 1'b0));
      // all zero, all largest, all smallest
      pending_mats.push_back(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      pending_mats.push_back(make_mat(32767, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767, 1'b0));
      pending_mats.push_back(make_mat(-32768, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768, 1'b0));
      // largest scalar part with extreme off-diagonal differences of mixed sign
      pending_mats.push_back(make_mat(32767, 32767, -32768, -32768, 32767,
                                      -32768, 32767, 32767, 32767, 1'b0));
      // largest magnitude on each vector lane
      pending_mats.push_back(make_mat(32767, 0, 0, 0, -32768, -32768, 0, 32767, -32768, 1'b0));
      pending_mats.push_back(make_mat(-32768, 0, 32767, 0, 32767, 0, -32768, 0, -32768, 1'b0));
      pending_mats.push_back(make_mat(-32768, -32768, 0, 32767, -32768, 0, 0, 0, 32767, 1'b0));
      // alternating bit patterns, not a rotation
      pending_mats.push_back(make_mat(21845, -21846, 21845, -21846, 21845,
                                      -21846, 21845, -21846, 21845, 1'b0));
      pending_mats.push_back(make_mat(-21846, 21845, -21846, 21845, -21846,
                                      21845, -21846, 21845, -21846, 1'b0));
      // half-turn one LSB short: scalar radicand of -1 must clamp to zero
      pending_mats.push_back(make_mat(16383, 0, 0, 0, -16384, 0, 0, 0, -16384, 1'b0));
      // rounding the other way on the vector lanes of a near-identity
      pending_mats.push_back(make_mat(16385, 1, -1, -1, 16385, 1, 1, -1, 16385, 1'b0));
      // let the pipeline drain completely before this one
      pending_mats.push_back(make_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1'b1));

      // Random: mostly rotations, the rest raw bits, extremes and small values
      for (int n = 0; n < RANDOM_MATS; n++) begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               for (int i = 0; i < 9; i++)
                  m.e[i] = rmq_pkg::elem_type'($urandom_range(0, 65535));
            end
            3, 4: begin
               for (int i = 0; i < 9; i++)
                  m.e[i] = pick_extreme();
            end
            5, 6: begin
               for (int i = 0; i < 9; i++)
                  m.e[i] = rmq_pkg::elem_type'(int'($urandom_range(0, 128)) - 64);
            end
            default: m = random_rotation();
         endcase
         m.drain = (n % DRAIN_PERIOD == DRAIN_PERIOD - 1);
         pending_mats.push_back(m);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // wait for the last transfer in, then for the pipeline to empty
      while (pending_mats.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_quats.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== rotation_matrix_to_quaternion_core.f =====
rtl/rmq_pkg.sv
rtl/rmq_radicand.sv
rtl/rmq_root_stage.sv
rtl/rmq_sign.sv
rtl/rotation_matrix_to_quaternion_core.sv
sim/rotation_matrix_to_quaternion_core_tb.sv
